// ===== src/sliding_window_nsigma_detector_assert.svh =====
// Assertion macros shared by the checker of the sliding-window detector.
// Each macro expands to one labeled concurrent assertion on a rising clock.
`ifndef SLIDING_WINDOW_NSIGMA_DETECTOR_ASSERT_SVH
`define SLIDING_WINDOW_NSIGMA_DETECTOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWND_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swnd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SWND_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swnd assertion failed");

`endif

// ===== src/swnd_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the sliding-window detector.
// No dependencies; used by all files but swnd_ram and the assertion header.
package swnd_pkg;

    // Window and field sizes.
    localparam int WINDOW_MAX  = 256;
    localparam int ADDR_W      = $clog2(WINDOW_MAX);
    localparam int MIN_HISTORY = 3;
    localparam int LEN_W       = 9;
    localparam int MULT_W      = 12;
    localparam int SAMPLE_W    = 24;
    localparam int SUM_W       = 33;
    localparam int SQSUM_W     = 57;
    localparam int BOUND_W     = 29;
    localparam int DELTA_W     = 28;
    localparam int FLAG_W      = 2;
    localparam int SEV_W       = 3;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGMA_MULT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED        = 2'd3;

    localparam logic [LEN_W-1:0]  WINDOW_LENGTH_RST = 9'd64;
    localparam logic [MULT_W-1:0] SIGMA_MULT_RST    = 12'd768;

    // Flag codes.
    localparam logic [FLAG_W-1:0] FLAG_NONE = 2'd0;
    localparam logic [FLAG_W-1:0] FLAG_HIGH = 2'd1;
    localparam logic [FLAG_W-1:0] FLAG_LOW  = 2'd2;

    localparam logic [SEV_W-1:0] SEV_NONE = 3'd0;
    localparam logic [SEV_W-1:0] SEV_MAX  = 3'd5;

    // Shared multiplier.
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DIFF_W = 65;
    localparam int SPLIT  = 28;

    // Iterative divider.
    localparam int DIV_DVD_W = 33;
    localparam int DIV_DVS_W = 29;
    localparam int DIV_CNT_W = $clog2(DIV_DVD_W + 1);

    // Iterative square root.
    localparam int SQRT_IN_W   = 66;
    localparam int SQRT_ROOT_W = SQRT_IN_W / 2;
    localparam int SQRT_REM_W  = SQRT_ROOT_W + 4;
    localparam int SQRT_CNT_W  = $clog2(SQRT_ROOT_W + 1);

    typedef struct packed {
        logic                 start;
        logic [DIV_DVD_W-1:0] dividend;
        logic [DIV_DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_DVD_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic                 start;
        logic [SQRT_IN_W-1:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic                   done;
        logic [SQRT_ROOT_W-1:0] root;
    } sqrt_rsp_t;

    // Five times a 24-bit value, by shift and add.
    function automatic logic [DIV_DVD_W-1:0] times5(input logic [SAMPLE_W-1:0] x);
        logic [DIV_DVD_W-1:0] xe;
        xe = DIV_DVD_W'(x);
        return (xe << 2) + xe;
    endfunction

    // Severity from floor(5*excess/bound): saturates at five.
    function automatic logic [SEV_W-1:0] sev_of(input logic [DIV_DVD_W-1:0] q);
        logic [SEV_W-1:0] s;
        if (q >= DIV_DVD_W'(4))
            s = SEV_MAX;
        else
            s = SEV_W'(q[1:0]) + 3'd1;
        return s;
    endfunction

endpackage

// ===== src/swnd_sample_if.sv =====
`timescale 1ns / 1ps
// Sample input channel: valid/ready handshake with one Q16.8 sample per beat.
// Depends on swnd_pkg.
interface swnd_sample_if;
    logic                           valid;
    logic                           ready;
    logic [swnd_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// ===== src/swnd_result_if.sv =====
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with one detector verdict per beat.
// Depends on swnd_pkg.
interface swnd_result_if;
    logic                                valid;
    logic                                ready;
    logic                                enough_history;
    logic [swnd_pkg::FLAG_W-1:0]         sigma_flag;
    logic [swnd_pkg::SEV_W-1:0]          sigma_severity;
    logic signed [swnd_pkg::BOUND_W-1:0] crossed_bound;
    logic [swnd_pkg::SAMPLE_W-1:0]       window_mean;
    logic [swnd_pkg::SAMPLE_W-1:0]       window_spread;
    logic                                threshold_hit;
    logic [swnd_pkg::SEV_W-1:0]          threshold_severity;

    modport source (output valid, output enough_history, output sigma_flag,
                    output sigma_severity, output crossed_bound, output window_mean,
                    output window_spread, output threshold_hit,
                    output threshold_severity, input ready);
    modport sink   (input valid, input enough_history, input sigma_flag,
                    input sigma_severity, input crossed_bound, input window_mean,
                    input window_spread, input threshold_hit,
                    input threshold_severity, output ready);
endinterface

// ===== src/swnd_cfg_if.sv =====
`timescale 1ns / 1ps
// Configuration write channel: valid/ready handshake carrying index and data.
// Depends on swnd_pkg.
interface swnd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [swnd_pkg::CFG_IDX_W-1:0]  index;
    logic [swnd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/swnd_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data (read before write).
// No dependencies.
module swnd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One access per cycle; the read returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/swnd_divider.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on swnd_pkg.
module swnd_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  swnd_pkg::div_req_t req,
    output swnd_pkg::div_rsp_t rsp
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [swnd_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [swnd_pkg::DIV_DVD_W-1:0]    dvd_reg;
    logic [swnd_pkg::DIV_DVS_W-1:0]    rem_reg;
    logic [swnd_pkg::DIV_DVS_W-1:0]    dvs_reg;
    logic [swnd_pkg::DIV_DVS_W:0]      rem_sh;
    logic                              qbit;

    // Shift in the next dividend bit and try the subtraction.
    assign rem_sh = {rem_reg, dvd_reg[swnd_pkg::DIV_DVD_W-1]};
    assign qbit   = (rem_sh >= {1'b0, dvs_reg});

    // Control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == swnd_pkg::DIV_CNT_W'(swnd_pkg::DIV_DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the quotient bits fill the dividend register from the bottom.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[swnd_pkg::DIV_DVD_W-2:0], qbit};
            if (qbit)
                rem_reg <= swnd_pkg::DIV_DVS_W'(rem_sh - {1'b0, dvs_reg});
            else
                rem_reg <= rem_sh[swnd_pkg::DIV_DVS_W-1:0];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

// ===== src/swnd_isqrt.sv =====
`timescale 1ns / 1ps
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on swnd_pkg.
module swnd_isqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  swnd_pkg::sqrt_req_t req,
    output swnd_pkg::sqrt_rsp_t rsp
);

    logic                               busy_reg;
    logic                               done_reg;
    logic [swnd_pkg::SQRT_CNT_W-1:0]    cnt_reg;
    logic [swnd_pkg::SQRT_IN_W-1:0]     rad_reg;
    logic [swnd_pkg::SQRT_REM_W-1:0]    rem_reg;
    logic [swnd_pkg::SQRT_ROOT_W-1:0]   root_reg;
    logic [swnd_pkg::SQRT_REM_W-1:0]    rem_sh;
    logic [swnd_pkg::SQRT_REM_W-1:0]    trial;
    logic                               rbit;

    // Bring down the next bit pair and test 4*root+1 against the remainder.
    assign rem_sh = {rem_reg[swnd_pkg::SQRT_REM_W-3:0],
                     rad_reg[swnd_pkg::SQRT_IN_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign rbit   = (rem_sh >= trial);

    // Control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == swnd_pkg::SQRT_CNT_W'(swnd_pkg::SQRT_ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rad_reg  <= req.radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[swnd_pkg::SQRT_IN_W-3:0], 2'b00};
            root_reg <= {root_reg[swnd_pkg::SQRT_ROOT_W-2:0], rbit};
            if (rbit)
                rem_reg <= rem_sh - trial;
            else
                rem_reg <= rem_sh;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule

// ===== src/sliding_window_nsigma_detector.sv =====
`timescale 1ns / 1ps
// Top level of the sliding-window n-sigma detector: sequencer, window store,
// shared multiplier, divider and square root. Depends on swnd_pkg, the
// channel interfaces, swnd_ram, swnd_divider and swnd_isqrt.
//
// Usage: samples (valid/ready) takes one Q16.8 sample per beat; results
// (valid/ready) returns exactly one verdict per sample, in order; cfg writes
// register 0 window_length, 1 sigma_multiplier, 2 fixed_threshold and is
// always ready. A window_length write empties the window.
// Each sample runs through a sequencer around one 33x33 multiplier, one
// restoring divider and one square root unit, both one bit per cycle. The
// 33-step square root and 33-step divisions (mean, spread, severities when
// they run) take most of the time per sample. samples.ready is high only
// while the sequencer is idle, so one sample is in work at a time.
// The result sits in an output register; when results stalls, the next
// sample is still accepted and computed and waits until the register frees.
// Reset: registers take their reset values (window_length 64, multiplier
// 3.0, threshold off) and the window is empty; no clearing pass is needed
// because an entry is taken as the outgoing sample only after it is written.
module sliding_window_nsigma_detector (
    input  logic                  clk,
    input  logic                  rst_n,
    swnd_cfg_if.sink              cfg,
    swnd_sample_if.sink           samples,
    swnd_result_if.source         results
);

    // Sequencer states.
    localparam logic [4:0] ST_IDLE        = 5'd0;
    localparam logic [4:0] ST_SQ_NEW      = 5'd1;
    localparam logic [4:0] ST_ADD_NEW     = 5'd2;
    localparam logic [4:0] ST_SUB_OLD     = 5'd3;
    localparam logic [4:0] ST_NS_LO       = 5'd4;
    localparam logic [4:0] ST_NS_HI       = 5'd5;
    localparam logic [4:0] ST_S1SQ        = 5'd6;
    localparam logic [4:0] ST_DIFF        = 5'd7;
    localparam logic [4:0] ST_SQRT        = 5'd8;
    localparam logic [4:0] ST_MEAN_GO     = 5'd9;
    localparam logic [4:0] ST_MEAN_WAIT   = 5'd10;
    localparam logic [4:0] ST_SPREAD_GO   = 5'd11;
    localparam logic [4:0] ST_SPREAD_WAIT = 5'd12;
    localparam logic [4:0] ST_DELTA       = 5'd13;
    localparam logic [4:0] ST_BOUND       = 5'd14;
    localparam logic [4:0] ST_SEV_GO      = 5'd15;
    localparam logic [4:0] ST_SEV_WAIT    = 5'd16;
    localparam logic [4:0] ST_THR_GO      = 5'd17;
    localparam logic [4:0] ST_THR_WAIT    = 5'd18;
    localparam logic [4:0] ST_DONE        = 5'd19;

    // Configuration and window state.
    logic [4:0]                          state_reg, state_next;
    logic [swnd_pkg::LEN_W-1:0]          window_length_reg;
    logic [swnd_pkg::MULT_W-1:0]         sigma_mult_reg;
    logic [swnd_pkg::SAMPLE_W-1:0]       fixed_thr_reg;
    logic [swnd_pkg::ADDR_W-1:0]         write_slot_reg;
    logic [swnd_pkg::LEN_W-1:0]          fill_reg;
    logic [swnd_pkg::SUM_W-1:0]          sum_reg;
    logic [swnd_pkg::SQSUM_W-1:0]        sqsum_reg;
    logic                                out_valid_reg;

    // Per-item datapath.
    logic [swnd_pkg::SAMPLE_W-1:0]       sample_reg;
    logic [swnd_pkg::SAMPLE_W-1:0]       old_reg;
    logic [swnd_pkg::ADDR_W-1:0]         slot_reg;
    logic [swnd_pkg::PROD_W-1:0]         prod_reg;
    logic [swnd_pkg::DIFF_W-1:0]         wide_reg;
    logic [swnd_pkg::SQRT_ROOT_W-1:0]    root_reg;
    logic [swnd_pkg::SAMPLE_W-1:0]       mean_reg;
    logic [swnd_pkg::SAMPLE_W-1:0]       spread_reg;
    logic                                enough_reg;
    logic [swnd_pkg::FLAG_W-1:0]         flag_reg;
    logic [swnd_pkg::SEV_W-1:0]          sev_reg;
    logic [swnd_pkg::BOUND_W-1:0]        bound_reg;
    logic [swnd_pkg::SAMPLE_W-1:0]       excess_reg;
    logic                                thit_reg;
    logic [swnd_pkg::SEV_W-1:0]          tsev_reg;

    // Output register.
    logic                                o_enough_reg;
    logic [swnd_pkg::FLAG_W-1:0]         o_flag_reg;
    logic [swnd_pkg::SEV_W-1:0]          o_sev_reg;
    logic [swnd_pkg::BOUND_W-1:0]        o_bound_reg;
    logic [swnd_pkg::SAMPLE_W-1:0]       o_mean_reg;
    logic [swnd_pkg::SAMPLE_W-1:0]       o_spread_reg;
    logic                                o_thit_reg;
    logic [swnd_pkg::SEV_W-1:0]          o_tsev_reg;

    // Combinational helpers.
    logic [swnd_pkg::LEN_W-1:0]          cap;
    logic                                full;
    logic [swnd_pkg::ADDR_W-1:0]         slot_now;
    logic [swnd_pkg::LEN_W-1:0]          slot_inc;
    logic                                in_fire;
    logic                                cfg_fire;
    logic                                out_free;
    logic [swnd_pkg::MUL_W-1:0]          mul_a, mul_b;
    logic [swnd_pkg::PROD_W-1:0]         mul_p;
    logic [swnd_pkg::DELTA_W-1:0]        delta;
    logic [swnd_pkg::BOUND_W-1:0]        upper;
    logic signed [swnd_pkg::BOUND_W:0]   lower;
    logic                                lower_pos;
    logic                                ram_we;
    logic [swnd_pkg::ADDR_W-1:0]         ram_addr;
    logic [swnd_pkg::SAMPLE_W-1:0]       ram_rdata;
    swnd_pkg::div_req_t                  div_req;
    swnd_pkg::div_rsp_t                  div_rsp;
    swnd_pkg::sqrt_req_t                 sqrt_req;
    swnd_pkg::sqrt_rsp_t                 sqrt_rsp;

    assign in_fire  = samples.valid && samples.ready;
    assign cfg_fire = cfg.valid && cfg.ready;
    assign out_free = !out_valid_reg || results.ready;

    assign samples.ready = (state_reg == ST_IDLE);
    assign cfg.ready     = 1'b1;

    // Effective window length: zero acts as one, clipped to the store depth.
    always_comb
    begin
        if (window_length_reg == '0)
            cap = swnd_pkg::LEN_W'(1);
        else if (window_length_reg > swnd_pkg::LEN_W'(swnd_pkg::WINDOW_MAX))
            cap = swnd_pkg::LEN_W'(swnd_pkg::WINDOW_MAX);
        else
            cap = window_length_reg;
    end

    assign full     = (fill_reg >= cap);
    assign slot_now = ({1'b0, write_slot_reg} >= cap) ? '0 : write_slot_reg;
    assign slot_inc = {1'b0, slot_reg} + 1'b1;

    // Window store: read the outgoing entry at accept, write the new one next.
    assign ram_we   = (state_reg == ST_SQ_NEW);
    assign ram_addr = (state_reg == ST_IDLE) ? slot_now : slot_reg;

    swnd_ram #(
        .WIDTH (swnd_pkg::SAMPLE_W),
        .DEPTH (swnd_pkg::WINDOW_MAX)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (sample_reg),
        .rdata (ram_rdata)
    );

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SQ_NEW:
            begin
                mul_a = swnd_pkg::MUL_W'(sample_reg);
                mul_b = swnd_pkg::MUL_W'(sample_reg);
            end
            ST_ADD_NEW:
            begin
                mul_a = swnd_pkg::MUL_W'(old_reg);
                mul_b = swnd_pkg::MUL_W'(old_reg);
            end
            ST_NS_LO:
            begin
                mul_a = swnd_pkg::MUL_W'(fill_reg);
                mul_b = swnd_pkg::MUL_W'(sqsum_reg[swnd_pkg::SPLIT-1:0]);
            end
            ST_NS_HI:
            begin
                mul_a = swnd_pkg::MUL_W'(fill_reg);
                mul_b = swnd_pkg::MUL_W'(sqsum_reg[2*swnd_pkg::SPLIT-1:swnd_pkg::SPLIT]);
            end
            ST_S1SQ:
            begin
                mul_a = swnd_pkg::MUL_W'(sum_reg[swnd_pkg::SUM_W-2:0]);
                mul_b = swnd_pkg::MUL_W'(sum_reg[swnd_pkg::SUM_W-2:0]);
            end
            ST_DELTA:
            begin
                mul_a = swnd_pkg::MUL_W'(sigma_mult_reg);
                mul_b = swnd_pkg::MUL_W'(spread_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Bounds around the mean.
    assign delta     = prod_reg[swnd_pkg::DELTA_W+7:8];
    assign upper     = swnd_pkg::BOUND_W'(mean_reg) + swnd_pkg::BOUND_W'(delta);
    assign lower     = $signed({6'b0, mean_reg}) - $signed({2'b0, delta});
    assign lower_pos = !lower[swnd_pkg::BOUND_W] && (lower != '0);

    // Requests to the shared divider and the square root unit.
    always_comb
    begin
        div_req = '0;
        unique case (state_reg)
            ST_MEAN_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = sum_reg;
                div_req.divisor  = swnd_pkg::DIV_DVS_W'(fill_reg);
            end
            ST_SPREAD_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = root_reg;
                div_req.divisor  = swnd_pkg::DIV_DVS_W'(fill_reg);
            end
            ST_SEV_GO:
            begin
                div_req.start    = (flag_reg != swnd_pkg::FLAG_NONE) && (bound_reg != '0);
                div_req.dividend = swnd_pkg::times5(excess_reg);
                div_req.divisor  = bound_reg;
            end
            ST_THR_GO:
            begin
                div_req.start    = (fixed_thr_reg != '0) && (sample_reg > fixed_thr_reg);
                div_req.dividend = swnd_pkg::times5(sample_reg - fixed_thr_reg);
                div_req.divisor  = swnd_pkg::DIV_DVS_W'(fixed_thr_reg);
            end
            default:
            begin
                div_req = '0;
            end
        endcase
    end

    assign sqrt_req.start    = (state_reg == ST_DIFF);
    assign sqrt_req.radicand = (wide_reg >= prod_reg[swnd_pkg::DIFF_W-1:0])
                             ? swnd_pkg::SQRT_IN_W'(wide_reg - prod_reg[swnd_pkg::DIFF_W-1:0])
                             : '0;

    swnd_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    swnd_isqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:        if (in_fire) state_next = ST_SQ_NEW;
            ST_SQ_NEW:      state_next = ST_ADD_NEW;
            ST_ADD_NEW:     state_next = full ? ST_SUB_OLD : ST_NS_LO;
            ST_SUB_OLD:     state_next = ST_NS_LO;
            ST_NS_LO:       state_next = ST_NS_HI;
            ST_NS_HI:       state_next = ST_S1SQ;
            ST_S1SQ:        state_next = ST_DIFF;
            ST_DIFF:        state_next = ST_SQRT;
            ST_SQRT:        if (sqrt_rsp.done) state_next = ST_MEAN_GO;
            ST_MEAN_GO:     state_next = ST_MEAN_WAIT;
            ST_MEAN_WAIT:   if (div_rsp.done) state_next = ST_SPREAD_GO;
            ST_SPREAD_GO:   state_next = ST_SPREAD_WAIT;
            ST_SPREAD_WAIT: if (div_rsp.done) state_next = ST_DELTA;
            ST_DELTA:       state_next = ST_BOUND;
            ST_BOUND:       state_next = ST_SEV_GO;
            ST_SEV_GO:      state_next = div_req.start ? ST_SEV_WAIT : ST_THR_GO;
            ST_SEV_WAIT:    if (div_rsp.done) state_next = ST_THR_GO;
            ST_THR_GO:      state_next = div_req.start ? ST_THR_WAIT : ST_DONE;
            ST_THR_WAIT:    if (div_rsp.done) state_next = ST_DONE;
            ST_DONE:        if (out_free) state_next = ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    // Control state: sequencer, configuration, window bookkeeping, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            window_length_reg <= swnd_pkg::WINDOW_LENGTH_RST;
            sigma_mult_reg    <= swnd_pkg::SIGMA_MULT_RST;
            fixed_thr_reg     <= '0;
            write_slot_reg    <= '0;
            fill_reg          <= '0;
            sum_reg           <= '0;
            sqsum_reg         <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Running sums: add the new sample, then drop the outgoing one when the window is full.
            if (state_reg == ST_ADD_NEW)
            begin
                sum_reg   <= sum_reg + swnd_pkg::SUM_W'(sample_reg);
                sqsum_reg <= sqsum_reg + swnd_pkg::SQSUM_W'(prod_reg[2*swnd_pkg::SAMPLE_W-1:0]);
                if (!full)
                    fill_reg <= fill_reg + 1'b1;
                write_slot_reg <= (slot_inc >= cap) ? '0 : slot_inc[swnd_pkg::ADDR_W-1:0];
            end
            else if (state_reg == ST_SUB_OLD)
            begin
                sum_reg   <= sum_reg - swnd_pkg::SUM_W'(old_reg);
                sqsum_reg <= sqsum_reg - swnd_pkg::SQSUM_W'(prod_reg[2*swnd_pkg::SAMPLE_W-1:0]);
            end

            // Output register handshake.
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;

            // Configuration writes; a window length write empties the window.
            if (cfg_fire)
            begin
                unique case (cfg.index)
                    swnd_pkg::REG_WINDOW_LENGTH:
                    begin
                        window_length_reg <= cfg.data[swnd_pkg::LEN_W-1:0];
                        write_slot_reg    <= '0;
                        fill_reg          <= '0;
                        sum_reg           <= '0;
                        sqsum_reg         <= '0;
                    end
                    swnd_pkg::REG_SIGMA_MULT:
                    begin
                        sigma_mult_reg <= cfg.data[swnd_pkg::MULT_W-1:0];
                    end
                    swnd_pkg::REG_FIXED_THRESHOLD:
                    begin
                        fixed_thr_reg <= cfg.data;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Per-item datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;

        if (in_fire)
        begin
            sample_reg <= samples.sample;
            slot_reg   <= slot_now;
        end

        if (state_reg == ST_SQ_NEW)
            old_reg <= ram_rdata;

        // n*S2 from two partial products, then minus S1 squared in ST_DIFF.
        if (state_reg == ST_NS_HI)
            wide_reg <= swnd_pkg::DIFF_W'(prod_reg);
        else if (state_reg == ST_S1SQ)
            wide_reg <= wide_reg + {prod_reg[swnd_pkg::DIFF_W-swnd_pkg::SPLIT-1:0],
                                    {swnd_pkg::SPLIT{1'b0}}};

        if (state_reg == ST_SQRT && sqrt_rsp.done)
            root_reg <= sqrt_rsp.root;

        if (state_reg == ST_MEAN_WAIT && div_rsp.done)
            mean_reg <= div_rsp.quotient[swnd_pkg::SAMPLE_W-1:0];

        if (state_reg == ST_SPREAD_WAIT && div_rsp.done)
            spread_reg <= div_rsp.quotient[swnd_pkg::SAMPLE_W-1:0];

        // Compare the sample against both bounds.
        if (state_reg == ST_BOUND)
        begin
            enough_reg <= (fill_reg >= swnd_pkg::LEN_W'(swnd_pkg::MIN_HISTORY));
            if ((fill_reg >= swnd_pkg::LEN_W'(swnd_pkg::MIN_HISTORY))
                && (swnd_pkg::BOUND_W'(sample_reg) > upper))
            begin
                flag_reg   <= swnd_pkg::FLAG_HIGH;
                bound_reg  <= upper;
                excess_reg <= swnd_pkg::SAMPLE_W'(swnd_pkg::BOUND_W'(sample_reg) - upper);
            end
            else if ((fill_reg >= swnd_pkg::LEN_W'(swnd_pkg::MIN_HISTORY)) && lower_pos
                     && ($signed({6'b0, sample_reg}) < lower))
            begin
                flag_reg   <= swnd_pkg::FLAG_LOW;
                bound_reg  <= lower[swnd_pkg::BOUND_W-1:0];
                excess_reg <= swnd_pkg::SAMPLE_W'(lower[swnd_pkg::BOUND_W-1:0]
                                                  - swnd_pkg::BOUND_W'(sample_reg));
            end
            else
            begin
                flag_reg   <= swnd_pkg::FLAG_NONE;
                bound_reg  <= '0;
                excess_reg <= '0;
            end
        end

        // Sigma severity; a zero bound saturates it.
        if (state_reg == ST_SEV_GO)
            sev_reg <= (flag_reg == swnd_pkg::FLAG_NONE) ? swnd_pkg::SEV_NONE : swnd_pkg::SEV_MAX;
        else if (state_reg == ST_SEV_WAIT && div_rsp.done)
            sev_reg <= swnd_pkg::sev_of(div_rsp.quotient);

        // Fixed threshold check.
        if (state_reg == ST_THR_GO)
        begin
            thit_reg <= div_req.start;
            tsev_reg <= swnd_pkg::SEV_NONE;
        end
        else if (state_reg == ST_THR_WAIT && div_rsp.done)
            tsev_reg <= swnd_pkg::sev_of(div_rsp.quotient);

        // Load the output register.
        if (state_reg == ST_DONE && out_free)
        begin
            o_enough_reg <= enough_reg;
            o_flag_reg   <= flag_reg;
            o_sev_reg    <= sev_reg;
            o_bound_reg  <= bound_reg;
            o_mean_reg   <= mean_reg;
            o_spread_reg <= spread_reg;
            o_thit_reg   <= thit_reg;
            o_tsev_reg   <= tsev_reg;
        end
    end

    assign results.valid              = out_valid_reg;
    assign results.enough_history     = o_enough_reg;
    assign results.sigma_flag         = o_flag_reg;
    assign results.sigma_severity     = o_sev_reg;
    assign results.crossed_bound      = $signed(o_bound_reg);
    assign results.window_mean        = o_mean_reg;
    assign results.window_spread      = o_spread_reg;
    assign results.threshold_hit      = o_thit_reg;
    assign results.threshold_severity = o_tsev_reg;

endmodule

// ===== src/swnd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker of the sliding-window detector, bound to the top level.
// Depends on swnd_pkg, the channel interfaces and the assertion macro header.
`include "sliding_window_nsigma_detector_assert.svh"

module swnd_port_checker (
    input  logic          clk,
    input  logic          rst_n,
    swnd_sample_if.sink   samples,
    swnd_result_if.source results
);

    // One sample in work at a time: no accept right after an accept.
    `SWND_ASSERT_NEXT(a_one_in_flight, clk, rst_n, samples.valid && samples.ready, !samples.ready)

    // A stalled result beat holds.
    `SWND_ASSERT_NEXT(a_stall_hold, clk, rst_n, results.valid && !results.ready, results.valid && $stable(results.window_mean) && $stable(results.sigma_flag))

    // Normal verdicts carry no severity and no bound.
    `SWND_ASSERT_SAME(a_quiet_normal, clk, rst_n, results.valid && (results.sigma_flag == swnd_pkg::FLAG_NONE), (results.sigma_severity == swnd_pkg::SEV_NONE) && (results.crossed_bound == '0))

    // A sigma flag needs history and a severity from one to five.
    `SWND_ASSERT_SAME(a_flag_sev, clk, rst_n, results.valid && (results.sigma_flag != swnd_pkg::FLAG_NONE), results.enough_history && (results.sigma_severity != swnd_pkg::SEV_NONE) && (results.sigma_severity <= swnd_pkg::SEV_MAX))

    // Threshold severity follows the hit bit.
    `SWND_ASSERT_SAME(a_thr_sev, clk, rst_n, results.valid, results.threshold_hit ? ((results.threshold_severity != swnd_pkg::SEV_NONE) && (results.threshold_severity <= swnd_pkg::SEV_MAX)) : (results.threshold_severity == swnd_pkg::SEV_NONE))

endmodule

bind sliding_window_nsigma_detector swnd_port_checker u_swnd_port_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .samples (samples),
    .results (results)
);

// ===== sim/swnd_checker.sv =====
`timescale 1ns / 1ps
// Checker of the sliding-window detector: watches the config, sample and result
// channels, predicts each verdict and compares it. Depends on swnd_pkg and the
// channel interfaces.
module swnd_checker (
    input  logic       clk,
    input  logic       rst_n,
    swnd_cfg_if        cfg,
    swnd_sample_if     samples,
    swnd_result_if     results,
    output int         fail_count,
    output int         pending_verdicts
);

    typedef struct packed {
        logic                               enough_history;
        logic [swnd_pkg::FLAG_W-1:0]        sigma_flag;
        logic [swnd_pkg::SEV_W-1:0]         sigma_severity;
        logic [swnd_pkg::BOUND_W-1:0]       crossed_bound;
        logic [swnd_pkg::SAMPLE_W-1:0]      window_mean;
        logic [swnd_pkg::SAMPLE_W-1:0]      window_spread;
        logic                               threshold_hit;
        logic [swnd_pkg::SEV_W-1:0]         threshold_severity;
    } verdict_t;

    // Shadow copy of the detector's registers and window.
    logic [swnd_pkg::LEN_W-1:0]    win_len;
    logic [swnd_pkg::MULT_W-1:0]   mult;
    logic [swnd_pkg::SAMPLE_W-1:0] thresh;
    logic [swnd_pkg::SAMPLE_W-1:0] ring [swnd_pkg::WINDOW_MAX];
    int unsigned                   slot;
    int unsigned                   filled;
    logic [63:0]                   sum1;
    logic [63:0]                   sum2;
    verdict_t                      verdict_fifo [$];

    // Severity of an excess over a bound, saturating at five.
    function automatic logic [swnd_pkg::SEV_W-1:0] severity(input logic [63:0] excess,
                                                            input logic [63:0] bound);
        logic [63:0] q;
        if (bound == 0)
            return swnd_pkg::SEV_MAX;
        q = (64'd5 * excess) / bound;
        return (q >= 4) ? swnd_pkg::SEV_MAX : swnd_pkg::SEV_W'(q + 1);
    endfunction

    // Floor square root of a 128-bit value, one bit at a time.
    function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = 0;
        for (int b = 63; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (128'(trial) * 128'(trial) <= v)
                root = trial;
        end
        return root;
    endfunction

    // Push one sample into the shadow window and work out its verdict.
    task automatic predict_verdict(input logic [swnd_pkg::SAMPLE_W-1:0] s);
        int unsigned     cap;
        logic [63:0]     se;
        logic [63:0]     old;
        logic [63:0]     n;
        logic [63:0]     mean;
        logic [63:0]     spread;
        logic [127:0]    lhs;
        logic [127:0]    rhs;
        longint          delta;
        longint          upper;
        longint          lower;
        verdict_t        v;
        cap = (win_len == 0) ? 1 : ((win_len > swnd_pkg::WINDOW_MAX)
              ? swnd_pkg::WINDOW_MAX : win_len);
        se = 64'(s);
        if (slot >= cap)
            slot = 0;
        if (filled < cap)
        begin
            filled++;
            sum1 += se;
            sum2 += se * se;
        end
        else
        begin
            old = 64'(ring[slot]);
            sum1 = sum1 - old + se;
            sum2 = sum2 - old * old + se * se;
        end
        ring[slot] = s;
        slot++;
        if (slot >= cap)
            slot = 0;
        n = 64'(filled);
        mean = sum1 / n;
        lhs = 128'(n) * 128'(sum2);
        rhs = 128'(sum1) * 128'(sum1);
        spread = floor_sqrt((lhs < rhs) ? 128'd0 : lhs - rhs) / n;
        v = '0;
        v.sigma_flag = swnd_pkg::FLAG_NONE;
        v.sigma_severity = swnd_pkg::SEV_NONE;
        v.threshold_severity = swnd_pkg::SEV_NONE;
        v.enough_history = (filled >= swnd_pkg::MIN_HISTORY);
        if (v.enough_history)
        begin
            delta = longint'((64'(mult) * spread) >> 8);
            upper = longint'(mean) + delta;
            lower = longint'(mean) - delta;
            if (longint'(se) > upper)
            begin
                v.sigma_flag = swnd_pkg::FLAG_HIGH;
                v.crossed_bound = swnd_pkg::BOUND_W'(upper);
                v.sigma_severity = severity(64'(longint'(se) - upper), 64'(upper));
            end
            else if (lower > 0 && longint'(se) < lower)
            begin
                v.sigma_flag = swnd_pkg::FLAG_LOW;
                v.crossed_bound = swnd_pkg::BOUND_W'(lower);
                v.sigma_severity = severity(64'(lower - longint'(se)), 64'(lower));
            end
        end
        if (thresh != 0 && s > thresh)
        begin
            v.threshold_hit = 1'b1;
            v.threshold_severity = severity(se - 64'(thresh), 64'(thresh));
        end
        v.window_mean = swnd_pkg::SAMPLE_W'(mean);
        v.window_spread = swnd_pkg::SAMPLE_W'(spread);
        verdict_fifo.push_back(v);
    endtask

    // Track config writes and samples, compare results against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t got;
        verdict_t want;
        if (!rst_n)
        begin
            win_len <= swnd_pkg::WINDOW_LENGTH_RST;
            mult <= swnd_pkg::SIGMA_MULT_RST;
            thresh <= '0;
            slot = 0;
            filled = 0;
            sum1 = 0;
            sum2 = 0;
            verdict_fifo.delete();
            fail_count <= 0;
            pending_verdicts = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    swnd_pkg::REG_WINDOW_LENGTH:
                    begin
                        win_len <= cfg.data[swnd_pkg::LEN_W-1:0];
                        slot = 0;
                        filled = 0;
                        sum1 = 0;
                        sum2 = 0;
                    end
                    swnd_pkg::REG_SIGMA_MULT:      mult <= cfg.data[swnd_pkg::MULT_W-1:0];
                    swnd_pkg::REG_FIXED_THRESHOLD: thresh <= cfg.data;
                    default: ;
                endcase
            end
            if (samples.valid && samples.ready)
                predict_verdict(samples.sample);
            if (results.valid && results.ready)
            begin
                got = {results.enough_history, results.sigma_flag, results.sigma_severity,
                       results.crossed_bound, results.window_mean, results.window_spread,
                       results.threshold_hit, results.threshold_severity};
                if (verdict_fifo.size() == 0)
                begin
                    $display("%0t: unexpected verdict, expected none, actual %h", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = verdict_fifo.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: verdict mismatch", $time);
                        $display("  expected hist=%0d flag=%0d sev=%0d bound=%0d mean=%0d",
                                 want.enough_history, want.sigma_flag, want.sigma_severity,
                                 $signed(want.crossed_bound), want.window_mean);
                        $display("    spread=%0d thit=%0d tsev=%0d", want.window_spread,
                                 want.threshold_hit, want.threshold_severity);
                        $display("  actual   hist=%0d flag=%0d sev=%0d bound=%0d mean=%0d",
                                 got.enough_history, got.sigma_flag, got.sigma_severity,
                                 $signed(got.crossed_bound), got.window_mean);
                        $display("    spread=%0d thit=%0d tsev=%0d", got.window_spread,
                                 got.threshold_hit, got.threshold_severity);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending_verdicts = verdict_fifo.size();
        end
    end

endmodule

// ===== sim/sliding_window_nsigma_detector_test.sv =====
`timescale 1ns / 1ps
// Testbench top of the sliding-window detector: drives config writes and samples,
// stalls the result side at random and gives the verdict. Depends on swnd_pkg,
// the channel interfaces, swnd_checker and the detector.
module sliding_window_nsigma_detector_test;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_verdicts;
    bit   hold_results;
    bit   stim_done;

    swnd_cfg_if    cfg ();
    swnd_sample_if samples ();
    swnd_result_if results ();

    sliding_window_nsigma_detector u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .samples (samples),
        .results (results)
    );

    swnd_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .samples          (samples),
        .results          (results),
        .fail_count       (fail_count),
        .pending_verdicts (pending_verdicts)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #20ms;
        $display("** sliding_window_nsigma_detector: FAILED **");
        $finish;
    end

    // Write one register and wait for its beat; a later send_sample or drain drops valid.
    task automatic write_reg(input logic [swnd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [swnd_pkg::CFG_DATA_W-1:0] d);
        samples.valid <= 1'b0;
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= d;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Send one sample after a random gap, or none when busy mode asks.
    task automatic send_sample(input logic [swnd_pkg::SAMPLE_W-1:0] s, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15));
        cfg.valid <= 1'b0;
        if (gap > 0)
        begin
            samples.valid <= 1'b0;
            repeat (gap)
                @(negedge clk);
        end
        samples.valid <= 1'b1;
        samples.sample <= s;
        @(posedge clk);
        while (!samples.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop both request channels, wait until every verdict is in, then a margin.
    task automatic drain;
        samples.valid <= 1'b0;
        cfg.valid <= 1'b0;
        while (pending_verdicts != 0)
            @(negedge clk);
        repeat (300)
            @(negedge clk);
    endtask

    // Sample near a level with a random spread.
    function automatic logic [swnd_pkg::SAMPLE_W-1:0] near(input int unsigned level,
                                                           input int unsigned span);
        longint v;
        v = longint'(level) + longint'($urandom_range(0, 2 * span)) - longint'(span);
        if (v < 0)
            v = 0;
        if (v > 24'hFFFFFF)
            v = 24'hFFFFFF;
        return swnd_pkg::SAMPLE_W'(v);
    endfunction

    // Result side: random stalls, with one long hold-off on request.
    initial
    begin
        int w;
        results.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_results)
            begin
                results.ready <= 1'b0;
                repeat (600)
                    @(negedge clk);
                hold_results = 1'b0;
            end
            w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
            if (w == 0 || stim_done)
                results.ready <= 1'b1;
            else
            begin
                results.ready <= 1'b0;
                repeat (w - 1)
                    @(negedge clk);
                @(negedge clk);
                results.ready <= 1'b1;
            end
        end
    end

    // Stimulus.
    initial
    begin
        int unsigned lens [6] = '{1, 3, 16, 64, 256, 511};
        int unsigned lvl;
        cfg.valid = 1'b0;
        cfg.index = swnd_pkg::REG_WINDOW_LENGTH;
        cfg.data = '0;
        samples.valid = 1'b0;
        samples.sample = '0;
        hold_results = 1'b0;
        stim_done = 1'b0;
        rst_n = 1'b0;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset settings, short history, extremes, both flags.
        send_sample(24'h000000, 0);
        send_sample(24'hFFFFFF, 0);
        send_sample(24'h000000, 0);
        send_sample(24'hFFFFFF, 0);
        for (int i = 0; i < 6; i++)
            send_sample(24'h001000, 0);
        send_sample(24'h000000, 0);
        send_sample(24'h001000, 0);
        send_sample(24'h800000, 0);
        drain();
        // Zero bound: all-zero history with zero multiplier, then a high sample.
        write_reg(swnd_pkg::REG_SIGMA_MULT, 24'd0);
        write_reg(swnd_pkg::REG_FIXED_THRESHOLD, 24'd1);
        write_reg(swnd_pkg::REG_WINDOW_LENGTH, 24'd0);
        send_sample(24'h000000, 0);
        send_sample(24'h000005, 0);
        drain();
        write_reg(swnd_pkg::REG_UNMAPPED, 24'hFFFFFF);
        write_reg(swnd_pkg::REG_WINDOW_LENGTH, 24'd4);
        for (int i = 0; i < 4; i++)
            send_sample(24'h000000, 0);
        send_sample(24'h000001, 0);
        send_sample(24'hFFFFFF, 0);
        drain();

        // Random phases over several settings.
        for (int ph = 0; ph < 14; ph++)
        begin
            write_reg(swnd_pkg::REG_WINDOW_LENGTH,
                      (ph == 0) ? 24'h1FF : 24'(lens[$urandom_range(0, 5)]));
            write_reg(swnd_pkg::REG_SIGMA_MULT, (ph == 1) ? 24'hFFF : ((ph == 2) ? 24'd0
                      : 24'($urandom_range(128, 1024))));
            write_reg(swnd_pkg::REG_FIXED_THRESHOLD, (ph == 3) ? 24'hFFFFFF
                      : (($urandom_range(0, 2) == 0)
                      ? 24'd0 : 24'($urandom_range(1, 24'hFFFFFF))));
            lvl = (ph % 3 == 0) ? $urandom_range(0, 24'hFFFFFF) : $urandom_range(0, 24'h4000);
            if (ph == 5)
                hold_results = 1'b1;
            for (int i = 0; i < 100; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_sample(24'($urandom()), ph == 5);
                else
                    send_sample(near(lvl, 1 + (lvl >> $urandom_range(2, 8))), ph == 5);
            end
            drain();
        end

        stim_done = 1'b1;
        drain();
        if (fail_count == 0)
            $display("** sliding_window_nsigma_detector: PASSED **");
        else
            $display("** sliding_window_nsigma_detector: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/swnd_pkg.sv
src/swnd_sample_if.sv
src/swnd_result_if.sv
src/swnd_cfg_if.sv
src/swnd_ram.sv
src/swnd_divider.sv
src/swnd_isqrt.sv
src/sliding_window_nsigma_detector.sv
src/swnd_checker.sv
sim/swnd_checker.sv
sim/sliding_window_nsigma_detector_test.sv
